FILE: sv/sorted_priority_queue_defines.svh
// Assertion macros used by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spq check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spq check failed");

`endif

FILE: sv/spq_pkg.sv
// Types, operation codes and the ordering function of the sorted priority queue.
package spq_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 80;
    localparam int unsigned COUNT_OUT_W = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic [DATA_W-1:0]        value;
    } entry_t;

    // Control shared by every cell of the chain.
    typedef struct packed {
        logic   cmp_en;
        logic   do_insert;
        logic   do_pop;
        logic   max_first;
        entry_t new_entry;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    function automatic logic ranks_above(input logic max_first,
                                         input logic signed [DATA_W-1:0] a,
                                         input logic signed [DATA_W-1:0] b);
        return max_first ? (a > b) : (a < b);
    endfunction

endpackage

FILE: sv/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it against a new item and shifts.
module spq_cell (
    input  logic               aclk,
    input  logic               is_head,
    input  logic               slot_valid,
    input  logic               hit_before,
    input  spq_pkg::cell_ctl_t ctl,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    slot_entry,
    output spq_pkg::entry_t    slot_entry_upd,
    output logic               slot_hit
);

    spq_pkg::entry_t entry_reg, entry_next;
    logic            hit_reg, hit_next;

    always_comb begin
        hit_next = hit_reg;
        if (ctl.cmp_en) begin
            // The head takes the new item only if it is empty or the item ranks strictly
            // above its entry; later slots take it when empty or when they do not rank above it.
            if (is_head) begin
                hit_next = !slot_valid ||
                    spq_pkg::ranks_above(ctl.max_first, ctl.new_entry.prio, entry_reg.prio);
            end else begin
                hit_next = !slot_valid ||
                    !spq_pkg::ranks_above(ctl.max_first, entry_reg.prio, ctl.new_entry.prio);
            end
        end
    end

    always_comb begin
        entry_next = entry_reg;
        if (ctl.do_insert) begin
            if (hit_before) begin
                entry_next = left_entry;
            end else if (hit_reg) begin
                entry_next = ctl.new_entry;
            end
        end else if (ctl.do_pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign slot_entry     = entry_reg;
    assign slot_entry_upd = entry_next;
    assign slot_hit       = hit_reg;

endmodule

FILE: sv/sorted_priority_queue.sv
// A transaction is accepted only in the idle state, so a new one is taken only after
// the last one has updated; each cell compares its slot in the accept cycle and the
// whole chain shifts in the update state that follows, and the result is registered.
// The update cycle waits while the output register holds an untaken result.
// Reset (aresetn low, synchronous) empties the queue and selects highest-first order.
module sorted_priority_queue #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic                            cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operation[1:0], item_value[33:2], item_priority[65:34], zero fill
    input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // head_valid[0], head_value[32:1], head_priority[64:33], entry_count[71:65],
    // dropped_full[72], zero fill
    output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned PAD_W = spq_pkg::M_TDATA_W - 2 * spq_pkg::DATA_W
                                    - spq_pkg::COUNT_OUT_W - 2;

    spq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             max_first_reg;
    logic [1:0]       op_reg;
    spq_pkg::entry_t  item_reg;
    logic             m_valid_reg, m_valid_next;
    logic [spq_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    spq_pkg::cell_ctl_t ctl;
    spq_pkg::entry_t    in_entry;
    spq_pkg::entry_t    cell_entry [CAPACITY];
    spq_pkg::entry_t    cell_entry_upd [CAPACITY];
    logic [CAPACITY-1:0] hit_vec, hit_prefix, hit_before;

    logic s_fire, out_free, upd_fire, is_full, is_empty, do_insert, do_pop, dropped;

    assign in_entry.value = s_tdata[33:2];
    assign in_entry.prio  = s_tdata[65:34];

    assign s_tready = (state_reg == spq_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb begin
        state_next = state_reg;
        upd_fire   = 1'b0;
        case (state_reg)
            spq_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = spq_pkg::ST_UPDATE;
                end
            end
            spq_pkg::ST_UPDATE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    upd_fire   = 1'b1;
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    assign do_insert = upd_fire && (op_reg == spq_pkg::OP_INSERT) && !is_full;
    assign do_pop    = upd_fire && (op_reg == spq_pkg::OP_POP) && !is_empty;
    assign dropped   = (op_reg == spq_pkg::OP_INSERT) && is_full;

    always_comb begin
        ctl.cmp_en    = s_fire;
        ctl.do_insert = do_insert;
        ctl.do_pop    = do_pop;
        ctl.max_first = max_first_reg;
        ctl.new_entry = (state_reg == spq_pkg::ST_IDLE) ? in_entry : item_reg;
    end

    // Inclusive prefix OR of the hit flags; a cell below the insert point sees it set.
    always_comb begin
        hit_prefix = hit_vec;
        for (int unsigned s = 1; s < CAPACITY; s = s * 2) begin
            hit_prefix = hit_prefix | (hit_prefix << s);
        end
        hit_before = hit_prefix << 1;
    end

    genvar j;
    generate
        for (j = 0; j < CAPACITY; j++) begin : g_cell
            spq_pkg::entry_t left_entry, right_entry;

            if (j == 0) begin : g_first
                assign left_entry = '0;
            end else begin : g_left
                assign left_entry = cell_entry[j-1];
            end

            if (j == CAPACITY - 1) begin : g_last
                assign right_entry = '0;
            end else begin : g_right
                assign right_entry = cell_entry[j+1];
            end

            spq_cell u_cell (
                .aclk           (aclk),
                .is_head        ((j == 0) ? 1'b1 : 1'b0),
                .slot_valid     (count_reg > CNT_W'(j)),
                .hit_before     (hit_before[j]),
                .ctl            (ctl),
                .left_entry     (left_entry),
                .right_entry    (right_entry),
                .slot_entry     (cell_entry[j]),
                .slot_entry_upd (cell_entry_upd[j]),
                .slot_hit       (hit_vec[j])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (upd_fire) begin
            m_valid_next = 1'b1;
            if (count_next != '0) begin
                m_data_next = {PAD_W'(0), dropped, spq_pkg::COUNT_OUT_W'(count_next),
                               cell_entry_upd[0].prio, cell_entry_upd[0].value, 1'b1};
            end else begin
                m_data_next = {PAD_W'(0), dropped, spq_pkg::COUNT_OUT_W'(count_next),
                               {(2 * spq_pkg::DATA_W){1'b0}}, 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= spq_pkg::ST_IDLE;
            count_reg     <= '0;
            max_first_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wen) begin
                max_first_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg   <= s_tdata[1:0];
            item_reg <= in_entry;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: sv/spq_checker.sv
// Port-level checks of the sorted priority queue, bound to its top level.
`include "sorted_priority_queue_defines.svh"

module spq_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [spq_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [spq_pkg::COUNT_OUT_W-1:0] full_count;
    logic                            s_fire;

    assign full_count = spq_pkg::COUNT_OUT_W'(CAPACITY);
    assign s_fire     = s_tvalid && s_tready;

    `SPQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `SPQ_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_fire, !s_tready)
    `SPQ_ASSERT_SAME(a_head_matches_count, aclk, aresetn, m_tvalid, m_tdata[0] == (m_tdata[71:65] != '0) || (CAPACITY >= 128))
    `SPQ_ASSERT_SAME(a_empty_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[64:1] == '0)
    `SPQ_ASSERT_SAME(a_drop_when_full, aclk, aresetn, m_tvalid && m_tdata[72], m_tdata[71:65] == full_count)

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
